[hdl/grid_raycast_wall_distance_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the grid ray caster.
// Shared property forms used by the top level of the core.
// ---------------------------------------------------------------------------
`ifndef GRID_RAYCAST_WALL_DISTANCE_CORE_MACROS_SVH
`define GRID_RAYCAST_WALL_DISTANCE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GRWD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GRWD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/grwd_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grwd_pkg
// Types, constants and codes shared by the ray caster controller, datapath
// and top level.
// ---------------------------------------------------------------------------
package grwd_pkg;

    localparam int MAP_COLS_DEF = 64;
    localparam int MAP_ROWS_DEF = 64;
    localparam int TILE_UNITS   = 64;
    localparam int FRAC_BITS    = 8;
    localparam int TILE_SHIFT   = FRAC_BITS + $clog2(TILE_UNITS);
    localparam int TRIG_SHIFT   = 14;
    localparam int QUARTER_TURN = 1 << TRIG_SHIFT;
    localparam int POS_W        = 20;
    localparam int POS_TILES    = 1 << (POS_W - TILE_SHIFT);
    localparam int SIN_W        = 15;
    localparam int DIV_W        = SIN_W + TILE_SHIFT;
    localparam int DIST_W       = 21;
    localparam int DIST_MAX     = (1 << DIST_W) - 1;
    localparam int CFG_W        = 7;
    localparam int CFG_IW       = 1;

    localparam logic [CFG_IW-1:0] CFG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_MAP_HEIGHT = 1'b1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [1:0] CELL_EMPTY = 2'd0;
    localparam logic [1:0] CELL_WALL  = 2'd1;
    localparam logic [1:0] CELL_DOOR  = 2'd2;
    localparam logic [1:0] CELL_OPEN  = 2'd3;

    localparam logic [1:0] HIT_WALL = 2'd0;
    localparam logic [1:0] HIT_DOOR = 2'd1;
    localparam logic [1:0] HIT_EDGE = 2'd2;

    localparam logic [1:0] TRIG_SIN  = 2'd0;
    localparam logic [1:0] TRIG_COS  = 2'd1;
    localparam logic [1:0] TRIG_VIEW = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_T_SETUP, ST_T_SQ, ST_T_R1, ST_T_R2, ST_T_S,
        ST_W_SETUP, ST_DIV_N, ST_SAVE_N, ST_DIV_S, ST_SAVE_S, ST_W_ADDR,
        ST_W_PROBE, ST_D_SQA, ST_D_SQB, ST_SQRT, ST_D_COR, ST_FIN
    } state_t;

    typedef enum logic [4:0] {
        DP_NOP, DP_CLR, DP_ACCEPT, DP_T_SETUP, DP_T_SQ, DP_T_R1, DP_T_R2,
        DP_T_S, DP_W_SETUP, DP_DIV, DP_SAVE_N, DP_SAVE_S, DP_W_ADDR,
        DP_W_PROBE, DP_D_SQA, DP_D_SQB, DP_SQRT, DP_D_COR, DP_FIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] sel;
        logic       axis;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic s_zero;
        logic c_zero;
        logic div_last;
        logic walk_stop;
        logic sqrt_last;
    } dp_stat_t;

endpackage

[hdl/grid_raycast_wall_distance_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_raycast_wall_distance_core
// Grid ray caster: holds a tile map and returns the fisheye-corrected
// distance, side, tile offset and kind of the first blocking hit of a ray.
// ---------------------------------------------------------------------------
//
// Channel   | Handshake              | Beat contents
// ----------+------------------------+-------------------------------------------
// command   | start high, busy low   | op, cell_row/col/kind, player_x/y, angles
// result    | done, one cycle        | distance, hit_side, hit_offset, hit_kind
// config    | cfg_we                 | cfg_index selects width/height, cfg_data
//
// A cell write (op 0) completes at the edge that accepts it and gives no beat.
// A cast (op 1) runs the trig evaluations, then per walk a setup, two
// 29-step divisions, a 32-step square root and the crossings, up to 66 crossings;
// the shared multiplier and one map read per crossing set its length.
// The result beat comes in the cycle in which busy falls. After reset a clearing pass
// writes every cell to empty, with busy high. No stalls.
// ---------------------------------------------------------------------------
`include "grid_raycast_wall_distance_core_macros.svh"

module grid_raycast_wall_distance_core #(
    parameter int MAP_COLS = grwd_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS = grwd_pkg::MAP_ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic [5:0]                    cell_row,
    input  logic [5:0]                    cell_col,
    input  logic [1:0]                    cell_kind,
    input  logic [grwd_pkg::POS_W-1:0]    player_x,
    input  logic [grwd_pkg::POS_W-1:0]    player_y,
    input  logic [15:0]                   ray_angle,
    input  logic signed [15:0]            view_offset,
    input  logic                          cfg_we,
    input  logic [grwd_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [grwd_pkg::CFG_W-1:0]    cfg_data,
    output logic                          done,
    output logic [grwd_pkg::DIST_W-1:0]   distance,
    output logic                          hit_side,
    output logic [5:0]                    hit_offset,
    output logic [1:0]                    hit_kind
);
    import grwd_pkg::*;

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [CFG_W-1:0]  map_width_reg, map_height_reg;

    // Map size registers; values beyond the storage act as the full size.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= CFG_W'(64);
            map_height_reg <= CFG_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                CFG_MAP_HEIGHT: map_height_reg <= cfg_data;
                default:        map_width_reg  <= map_width_reg;
            endcase
        end
    end

    // The controller sequences every step; the datapath only acts on its command.
    grwd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    grwd_dp #(
        .MAP_COLS (MAP_COLS),
        .MAP_ROWS (MAP_ROWS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .op          (op),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .cell_kind   (cell_kind),
        .player_x    (player_x),
        .player_y    (player_y),
        .ray_angle   (ray_angle),
        .view_offset (view_offset),
        .map_width   (map_width_reg),
        .map_height  (map_height_reg),
        .distance    (distance),
        .hit_side    (hit_side),
        .hit_offset  (hit_offset),
        .hit_kind    (hit_kind),
        .done        (done)
    );

    // A result beat only follows work the core was busy with.
    `GRWD_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result beat without a cast")
    // A result never carries the open-door code as its kind.
    `GRWD_ASSERT_SAME(a_kind_legal, done, hit_kind != 2'd3, "illegal hit kind")
    // An accepted cast keeps the core busy in the following cycle.
    `GRWD_ASSERT_NEXT(a_cast_busy, start && !busy && (op == OP_CAST), busy,
        "cast accepted but core idle")

endmodule

[hdl/grwd_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grwd_ctrl
// Sequencer of the ray caster: steps the datapath through the clear pass,
// the trig evaluations, one or both walks with a square root each and the final pick.
// ---------------------------------------------------------------------------
module grwd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               op,
    input  grwd_pkg::dp_stat_t stat,
    output grwd_pkg::dp_cmd_t  cmd,
    output logic               busy
);
    import grwd_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic       axis_reg, axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            sel_reg   <= TRIG_SIN;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        axis_next  = axis_reg;
        cmd.op     = DP_NOP;
        cmd.sel    = sel_reg;
        cmd.axis   = axis_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = DP_CLR;
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op = DP_ACCEPT;
                    if (op == OP_CAST)
                    begin
                        sel_next   = TRIG_SIN;
                        state_next = ST_T_SETUP;
                    end
                end
            end
            ST_T_SETUP: begin cmd.op = DP_T_SETUP; state_next = ST_T_SQ; end
            ST_T_SQ:    begin cmd.op = DP_T_SQ;    state_next = ST_T_R1; end
            ST_T_R1:    begin cmd.op = DP_T_R1;    state_next = ST_T_R2; end
            ST_T_R2:    begin cmd.op = DP_T_R2;    state_next = ST_T_S;  end
            ST_T_S:
            begin
                cmd.op = DP_T_S;
                if (sel_reg == TRIG_VIEW)
                begin
                    // Sine is already stored; a flat ray skips the y walk.
                    axis_next  = stat.s_zero;
                    state_next = ST_W_SETUP;
                end
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = ST_T_SETUP;
                end
            end
            ST_W_SETUP: begin cmd.op = DP_W_SETUP; state_next = ST_DIV_N; end
            ST_DIV_N:
            begin
                cmd.op = DP_DIV;
                if (stat.div_last)
                    state_next = ST_SAVE_N;
            end
            ST_SAVE_N:  begin cmd.op = DP_SAVE_N; state_next = ST_DIV_S; end
            ST_DIV_S:
            begin
                cmd.op = DP_DIV;
                if (stat.div_last)
                    state_next = ST_SAVE_S;
            end
            ST_SAVE_S:  begin cmd.op = DP_SAVE_S; state_next = ST_W_ADDR; end
            ST_W_ADDR:  begin cmd.op = DP_W_ADDR; state_next = ST_W_PROBE; end
            ST_W_PROBE:
            begin
                cmd.op = DP_W_PROBE;
                state_next = stat.walk_stop ? ST_D_SQA : ST_W_ADDR;
            end
            ST_D_SQA:   begin cmd.op = DP_D_SQA; state_next = ST_D_SQB; end
            ST_D_SQB:   begin cmd.op = DP_D_SQB; state_next = ST_SQRT;  end
            ST_SQRT:
            begin
                cmd.op = DP_SQRT;
                if (stat.sqrt_last)
                    state_next = ST_D_COR;
            end
            ST_D_COR:
            begin
                cmd.op = DP_D_COR;
                if (!axis_reg && !stat.c_zero)
                begin
                    axis_next  = 1'b1;
                    state_next = ST_W_SETUP;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:     begin cmd.op = DP_FIN; state_next = ST_IDLE; end
            default:    state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[hdl/grwd_dp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grwd_dp
// Datapath of the ray caster: map memory, shared multiplier, restoring
// divider, incremental crossing stepper and bit-pair square root.
// ---------------------------------------------------------------------------
module grwd_dp #(
    parameter int MAP_COLS = grwd_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS = grwd_pkg::MAP_ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  grwd_pkg::dp_cmd_t             cmd,
    output grwd_pkg::dp_stat_t            stat,
    input  logic                          op,
    input  logic [5:0]                    cell_row,
    input  logic [5:0]                    cell_col,
    input  logic [1:0]                    cell_kind,
    input  logic [grwd_pkg::POS_W-1:0]    player_x,
    input  logic [grwd_pkg::POS_W-1:0]    player_y,
    input  logic [15:0]                   ray_angle,
    input  logic signed [15:0]            view_offset,
    input  logic [grwd_pkg::CFG_W-1:0]    map_width,
    input  logic [grwd_pkg::CFG_W-1:0]    map_height,
    output logic [grwd_pkg::DIST_W-1:0]   distance,
    output logic                          hit_side,
    output logic [5:0]                    hit_offset,
    output logic [1:0]                    hit_kind,
    output logic                          done
);
    import grwd_pkg::*;

    localparam int DEPTH      = MAP_ROWS * MAP_COLS;
    localparam int AW         = $clog2(DEPTH);
    localparam int RW         = $clog2(MAP_ROWS);
    localparam int CW         = $clog2(MAP_COLS);
    localparam int WALK_LIMIT = ((MAP_COLS > MAP_ROWS) ? MAP_COLS : MAP_ROWS) + 2;
    localparam int KW         = $clog2(WALK_LIMIT);
    localparam int IW         = $clog2(POS_TILES + WALK_LIMIT + 2) + 1;
    localparam int ADW        = TILE_SHIFT + $clog2(WALK_LIMIT + 1) + 1;
    localparam int QW         = DIV_W + $clog2(WALK_LIMIT + 1) + 1;
    localparam int BW         = QW + 2;
    localparam int MW         = 31;
    localparam int SW         = 63;
    localparam logic [MW-1:0] CLAMP = MW'(64'd1 << 30);
    localparam logic [SIN_W-1:0] TR_RAW = SIN_W'(1 << TILE_SHIFT);
    localparam logic [SIN_W-1:0] QTR    = SIN_W'(QUARTER_TURN);

    // Map memory.
    logic [1:0]    mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [1:0]    mem_wdata, rdata_reg;

    // Control registers.
    logic [AW-1:0] clr_cnt_reg;
    logic [4:0]    it_cnt_reg;
    logic [KW-1:0] k_reg;
    logic          done_reg;

    // Payload registers.
    logic [POS_W-1:0]        px_reg, py_reg, pb_reg;
    logic [15:0]             ang_reg, view_reg;
    logic [SIN_W-1:0]        t_reg, t2_reg, r_reg, uca_reg, ucb_reg, rm_reg, sr_reg;
    logic                    neg_reg, ca_pos_reg, cb_neg_reg, edge_reg;
    logic signed [15:0]      sin_reg, cos_reg, cov_reg;
    logic signed [IW-1:0]    idx_reg;
    logic [ADW-1:0]          ada_reg;
    logic [QW-1:0]           q_reg;
    logic [DIV_W-1:0]        sq_reg, dnum_reg;
    logic [SIN_W:0]          drem_reg;
    logic signed [BW-1:0]    b_reg;
    logic [1:0]              kind_reg, ky_reg, kx_reg;
    logic [SW-1:0]           sv_reg, sres_reg, sbit_reg;
    logic [MW-1:0]           dyc_reg, dxc_reg;
    logic [5:0]              offy_reg, offx_reg;
    logic [DIST_W-1:0]       distance_reg;
    logic                    side_reg;
    logic [5:0]              offset_reg;
    logic [1:0]              hkind_reg;

    // Combinational signals.
    logic [15:0]          ang_src;
    logic [SIN_W-1:0]     t_src, ucos, uca_w, ucb_w, ada0;
    logic signed [15:0]   ca_w, cb_w;
    logic [POS_W-1:0]     pa_w, pb_w;
    logic signed [IW-1:0] idx0;
    logic [MW-1:0]        mul_a, mul_b, mb;
    logic [2*MW-1:0]      prod;
    logic [SIN_W:0]       rem_sh, rsum;
    logic                 div_bit;
    logic signed [BW-1:0] b_w;
    logic [8:0]           w_eff, h_eff;
    logic                 idx_edge, b_edge, walk_edge;
    logic [RW-1:0]        row_i;
    logic [CW-1:0]        col_i;
    logic                 blocked, stop_w;
    logic [SW-1:0]        s_trial;
    logic                 use_x;
    logic [MW-1:0]        d_sel;

    assign w_eff = (32'(map_width) < MAP_COLS) ? 9'(map_width) : 9'(MAP_COLS);
    assign h_eff = (32'(map_height) < MAP_ROWS) ? 9'(map_height) : 9'(MAP_ROWS);

    // Trig operand selection.
    always_comb
    begin
        case (cmd.sel)
            TRIG_SIN: ang_src = ang_reg;
            TRIG_COS: ang_src = ang_reg + 16'h4000;
            default:  ang_src = view_reg + 16'h4000;
        endcase
        t_src = ang_src[14] ? (QTR - {1'b0, ang_src[13:0]}) : {1'b0, ang_src[13:0]};
    end

    assign ucos = cov_reg[15] ? SIN_W'(-cov_reg) : cov_reg[SIN_W-1:0];

    // Walk setup: the stepped axis a and the other axis b.
    always_comb
    begin
        ca_w  = cmd.axis ? cos_reg : sin_reg;
        cb_w  = cmd.axis ? sin_reg : cos_reg;
        pa_w  = cmd.axis ? px_reg : py_reg;
        pb_w  = cmd.axis ? py_reg : px_reg;
        uca_w = ca_w[15] ? SIN_W'(-ca_w) : ca_w[SIN_W-1:0];
        ucb_w = cb_w[15] ? SIN_W'(-cb_w) : cb_w[SIN_W-1:0];
        ada0  = ca_w[15] ? {1'b0, pa_w[TILE_SHIFT-1:0]}
                         : (TR_RAW - {1'b0, pa_w[TILE_SHIFT-1:0]});
        idx0  = ca_w[15] ? (IW'(pa_w[POS_W-1:TILE_SHIFT]) - IW'(1))
                         : (IW'(pa_w[POS_W-1:TILE_SHIFT]) + IW'(1));
    end

    assign mb = (q_reg >= QW'(CLAMP)) ? CLAMP : q_reg[MW-1:0];

    // Shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            DP_T_SQ:    begin mul_a = MW'(t_reg);  mul_b = MW'(t_reg); end
            DP_T_R1:    begin mul_a = MW'(t2_reg); mul_b = MW'(1160);  end
            DP_T_R2:    begin mul_a = MW'(t2_reg); mul_b = MW'(r_reg); end
            DP_T_S:     begin mul_a = MW'(t_reg);  mul_b = MW'(r_reg); end
            DP_W_SETUP: begin mul_a = MW'(ada0);   mul_b = MW'(ucb_w); end
            DP_D_SQA:   begin mul_a = MW'(ada_reg); mul_b = MW'(ada_reg); end
            DP_D_SQB:   begin mul_a = mb;          mul_b = mb;         end
            DP_D_COR:   begin mul_a = sres_reg[MW-1:0]; mul_b = MW'(ucos); end
            default:    begin mul_a = '0;          mul_b = '0;         end
        endcase
        prod = mul_a * mul_b;
    end

    // Divider step and crossing stepper.
    assign rem_sh  = {drem_reg[SIN_W-1:0], dnum_reg[DIV_W-1]};
    assign div_bit = (rem_sh >= {1'b0, uca_reg});
    assign rsum    = {1'b0, rm_reg} + {1'b0, sr_reg};

    // Crossing point on the other axis and the cell that holds it.
    always_comb
    begin
        b_w = cb_neg_reg ? ($signed(BW'(pb_reg)) - $signed(BW'(q_reg)))
                         : ($signed(BW'(pb_reg)) + $signed(BW'(q_reg)));
        idx_edge = idx_reg[IW-1] ||
                   (32'($unsigned(idx_reg)) >= (cmd.axis ? 32'(w_eff) : 32'(h_eff)));
        b_edge   = b_w[BW-1] ||
                   (64'($unsigned(b_w[BW-1:TILE_SHIFT])) >=
                    (cmd.axis ? 64'(h_eff) : 64'(w_eff)));
        walk_edge = idx_edge || b_edge;
        if (cmd.axis)
        begin
            row_i = b_w[TILE_SHIFT +: RW];
            col_i = CW'($unsigned(idx_reg));
        end
        else
        begin
            row_i = RW'($unsigned(idx_reg));
            col_i = b_w[TILE_SHIFT +: CW];
        end
        mem_raddr = AW'(32'(row_i) * MAP_COLS + 32'(col_i));
    end

    assign blocked = edge_reg || (rdata_reg == CELL_WALL) || (rdata_reg == CELL_DOOR);
    assign stop_w  = blocked || (32'(k_reg) == WALK_LIMIT - 1);
    assign s_trial = sres_reg + sbit_reg;

    // Final pick: a tie goes to the x walk.
    always_comb
    begin
        if (sin_reg == 16'sd0)
            use_x = 1'b1;
        else if (cos_reg == 16'sd0)
            use_x = 1'b0;
        else
            use_x = (dxc_reg <= dyc_reg);
        d_sel = use_x ? dxc_reg : dyc_reg;
    end

    // Memory write port: clear pass or a cell write.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = CELL_EMPTY;
        if (cmd.op == DP_CLR)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.op == DP_ACCEPT && op == OP_WRITE)
        begin
            mem_we    = (32'(cell_row) < MAP_ROWS) && (32'(cell_col) < MAP_COLS);
            mem_waddr = AW'(32'(cell_row) * MAP_COLS + 32'(cell_col));
            mem_wdata = cell_kind;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            it_cnt_reg  <= '0;
            k_reg       <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.op == DP_FIN);
            case (cmd.op)
                DP_CLR:     clr_cnt_reg <= clr_cnt_reg + AW'(1);
                DP_W_SETUP: begin it_cnt_reg <= '0; k_reg <= '0; end
                DP_SAVE_N:  it_cnt_reg <= '0;
                DP_DIV:     it_cnt_reg <= it_cnt_reg + 5'd1;
                DP_SQRT:    it_cnt_reg <= it_cnt_reg + 5'd1;
                DP_D_SQB:   it_cnt_reg <= '0;
                DP_W_PROBE:
                begin
                    if (!stop_w)
                        k_reg <= k_reg + KW'(1);
                end
                default:    it_cnt_reg <= it_cnt_reg;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_ACCEPT:
            begin
                px_reg   <= player_x;
                py_reg   <= player_y;
                ang_reg  <= ray_angle;
                view_reg <= view_offset;
            end
            DP_T_SETUP:
            begin
                t_reg   <= t_src;
                neg_reg <= ang_src[15];
            end
            DP_T_SQ: t2_reg <= prod[TRIG_SHIFT +: SIN_W];
            DP_T_R1: r_reg  <= SIN_W'(10512) - prod[TRIG_SHIFT +: SIN_W];
            DP_T_R2: r_reg  <= SIN_W'(25736) - prod[TRIG_SHIFT +: SIN_W];
            DP_T_S:
            begin
                case (cmd.sel)
                    TRIG_SIN: sin_reg <= neg_reg ? -$signed({1'b0, prod[TRIG_SHIFT +: SIN_W]})
                                                 : $signed({1'b0, prod[TRIG_SHIFT +: SIN_W]});
                    TRIG_COS: cos_reg <= neg_reg ? -$signed({1'b0, prod[TRIG_SHIFT +: SIN_W]})
                                                 : $signed({1'b0, prod[TRIG_SHIFT +: SIN_W]});
                    default:  cov_reg <= neg_reg ? -$signed({1'b0, prod[TRIG_SHIFT +: SIN_W]})
                                                 : $signed({1'b0, prod[TRIG_SHIFT +: SIN_W]});
                endcase
            end
            DP_W_SETUP:
            begin
                uca_reg    <= uca_w;
                ucb_reg    <= ucb_w;
                ca_pos_reg <= !ca_w[15];
                cb_neg_reg <= cb_w[15];
                pb_reg     <= pb_w;
                idx_reg    <= idx0;
                ada_reg    <= ADW'(ada0);
                dnum_reg   <= prod[DIV_W-1:0];
                drem_reg   <= '0;
            end
            DP_DIV:
            begin
                drem_reg <= div_bit ? (rem_sh - {1'b0, uca_reg}) : rem_sh;
                dnum_reg <= {dnum_reg[DIV_W-2:0], div_bit};
            end
            DP_SAVE_N:
            begin
                q_reg    <= QW'(dnum_reg);
                rm_reg   <= drem_reg[SIN_W-1:0];
                dnum_reg <= {ucb_reg, {TILE_SHIFT{1'b0}}};
                drem_reg <= '0;
            end
            DP_SAVE_S:
            begin
                sq_reg <= dnum_reg;
                sr_reg <= drem_reg[SIN_W-1:0];
            end
            DP_W_ADDR:
            begin
                b_reg    <= b_w;
                edge_reg <= walk_edge;
            end
            DP_W_PROBE:
            begin
                if (stop_w)
                begin
                    if (edge_reg)
                        kind_reg <= HIT_EDGE;
                    else if (rdata_reg == CELL_WALL)
                        kind_reg <= HIT_WALL;
                    else if (rdata_reg == CELL_DOOR)
                        kind_reg <= HIT_DOOR;
                    else
                        kind_reg <= HIT_EDGE;
                end
                else
                begin
                    idx_reg <= ca_pos_reg ? (idx_reg + IW'(1)) : (idx_reg - IW'(1));
                    ada_reg <= ada_reg + ADW'(TR_RAW);
                    if (rsum >= {1'b0, uca_reg})
                    begin
                        rm_reg <= SIN_W'(rsum - {1'b0, uca_reg});
                        q_reg  <= q_reg + QW'(sq_reg) + QW'(1);
                    end
                    else
                    begin
                        rm_reg <= rsum[SIN_W-1:0];
                        q_reg  <= q_reg + QW'(sq_reg);
                    end
                end
            end
            DP_D_SQA: sv_reg <= SW'(prod);
            DP_D_SQB:
            begin
                sv_reg   <= sv_reg + SW'(prod);
                sres_reg <= '0;
                sbit_reg <= SW'(64'd1 << 62);
            end
            DP_SQRT:
            begin
                if (sv_reg >= s_trial)
                begin
                    sv_reg   <= sv_reg - s_trial;
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end
                else
                begin
                    sres_reg <= sres_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            DP_D_COR:
            begin
                if (cmd.axis)
                begin
                    dxc_reg  <= prod[TRIG_SHIFT +: MW];
                    kx_reg   <= kind_reg;
                    offx_reg <= b_reg[FRAC_BITS +: 6];
                end
                else
                begin
                    dyc_reg  <= prod[TRIG_SHIFT +: MW];
                    ky_reg   <= kind_reg;
                    offy_reg <= b_reg[FRAC_BITS +: 6];
                end
            end
            DP_FIN:
            begin
                distance_reg <= (d_sel > MW'(DIST_MAX)) ? DIST_W'(DIST_MAX) : d_sel[DIST_W-1:0];
                side_reg     <= use_x;
                offset_reg   <= use_x ? offx_reg : offy_reg;
                hkind_reg    <= use_x ? kx_reg : ky_reg;
            end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase
    end

    assign stat.clr_last  = (clr_cnt_reg == AW'(DEPTH - 1));
    assign stat.s_zero    = (sin_reg == 16'sd0);
    assign stat.c_zero    = (cos_reg == 16'sd0);
    assign stat.div_last  = (it_cnt_reg == 5'(DIV_W - 1));
    assign stat.walk_stop = stop_w;
    assign stat.sqrt_last = (it_cnt_reg == 5'd31);

    assign distance   = distance_reg;
    assign hit_side   = side_reg;
    assign hit_offset = offset_reg;
    assign hit_kind   = hkind_reg;
    assign done       = done_reg;

endmodule
